### design/ecbd_pkg.sv
// ----------------------------------------------------------------------------
// ecbd_pkg
// Shared types, constants and the command table of the escape-command baud
// detector.
// ----------------------------------------------------------------------------
package ecbd_pkg;

    localparam int MAX_LEN_DEFAULT = 48;

    localparam int HDR_LEN  = 11;
    localparam int NUM_CMDS = 3;
    localparam int PL_W     = 6;            // payload_length register width
    localparam int FIRE_W   = PL_W + 1;     // HDR_LEN + 1 + payload_length fits here
    localparam int CODE_W   = 2;

    localparam logic [PL_W-1:0] PAYLOAD_LEN_RESET = PL_W'(24);

    localparam logic [7:0] CHAR_ESC = 8'h1B;
    localparam logic [7:0] CHAR_L   = 8'h4C;
    localparam logic [7:0] CHAR_F   = 8'h46;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_FIRE    = 4'b1000
    } phase_t;

    // Byte at position pos of command cmd: ESC "XRELOA?" " LF"
    function automatic logic [7:0] cmd_byte(input logic [1:0] cmd, input logic [3:0] pos);
        logic [7:0] b;
        unique case (pos)
            4'd0:    b = CHAR_ESC;
            4'd1:    b = 8'h58;    // X
            4'd2:    b = 8'h52;    // R
            4'd3:    b = 8'h45;    // E
            4'd4:    b = 8'h4C;    // L
            4'd5:    b = 8'h4F;    // O
            4'd6:    b = 8'h41;    // A
            4'd7: begin
                unique case (cmd)
                    2'd0:    b = 8'h46;    // F
                    2'd1:    b = 8'h44;    // D
                    default: b = 8'h47;    // G
                endcase
            end
            4'd8:    b = 8'h20;    // space
            4'd9:    b = CHAR_L;
            4'd10:   b = CHAR_F;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### design/escape_command_baud_detector_unit.sv
// ----------------------------------------------------------------------------
// escape_command_baud_detector_unit
// Byte-stream parser that recognizes an ESC-started reload command, skips a
// configurable payload and pulses a baud-select code on the following byte.
// ----------------------------------------------------------------------------
// One byte is taken per transaction and produces exactly one result
// transaction. The parser state and the result register update in the same
// cycle, so a byte can be accepted every clock cycle; the result register
// holds the previous result until m_ready, and s_ready stays high whenever
// that register is empty or being drained. m_valid rises in the cycle after input
// acceptance. payload_length is written through cfg_we/cfg_wdata
// and is sampled on every payload byte, so write it only while idle.
module escape_command_baud_detector_unit #(
    parameter int MAX_LEN = ecbd_pkg::MAX_LEN_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_we,
    input  logic [ecbd_pkg::PL_W-1:0] cfg_wdata,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_byte_in,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_rate_change,
    output logic [ecbd_pkg::CODE_W-1:0] m_rate_code,
    output logic                        m_header_matched,
    output logic                        m_length_overflow
);

    // count can briefly reach MAX_LEN + 1 at a mismatched header end
    localparam int CNT_W = $clog2(MAX_LEN + 2);

    logic [ecbd_pkg::PL_W-1:0]     payload_len_reg;

    ecbd_pkg::phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [ecbd_pkg::NUM_CMDS-1:0] cand_reg, cand_next;
    logic [ecbd_pkg::CODE_W-1:0]   sel_reg, sel_next;
    logic                          after_l_reg, after_l_next;

    logic                          m_valid_reg;
    logic                          fire_reg, matched_reg, ovf_reg;
    logic [ecbd_pkg::CODE_W-1:0]   code_reg;

    logic                          s_accept;
    logic                          fire, matched, ovf;
    logic [ecbd_pkg::CODE_W-1:0]   code;
    logic [CNT_W-1:0]              cnt_inc;
    logic [ecbd_pkg::NUM_CMDS-1:0] cand_upd;
    logic [ecbd_pkg::CODE_W-1:0]   first_cand;
    logic [ecbd_pkg::FIRE_W-1:0]   fire_at;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign fire_at = ecbd_pkg::FIRE_W'(ecbd_pkg::HDR_LEN + 1)
                     + ecbd_pkg::FIRE_W'(payload_len_reg);

    // narrow the candidate set with the byte stored at position cnt_reg
    always_comb begin
        for (int k = 0; k < ecbd_pkg::NUM_CMDS; k++) begin
            cand_upd[k] = cand_reg[k]
                && (cnt_reg < CNT_W'(ecbd_pkg::HDR_LEN))
                && (ecbd_pkg::cmd_byte(2'(k), cnt_reg[3:0]) == s_byte_in);
        end
    end

    // lowest matching command wins
    always_comb begin
        first_cand = '0;
        for (int k = ecbd_pkg::NUM_CMDS - 1; k >= 0; k--) begin
            if (cand_upd[k]) begin
                first_cand = ecbd_pkg::CODE_W'(k);
            end
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        cand_next    = cand_reg;
        sel_next     = sel_reg;
        after_l_next = after_l_reg;
        fire         = 1'b0;
        code         = '0;
        matched      = 1'b0;
        ovf          = 1'b0;

        unique case (phase_reg)
            ecbd_pkg::PH_IDLE: begin
                if (s_byte_in == ecbd_pkg::CHAR_ESC) begin
                    cnt_next     = CNT_W'(1);
                    cand_next    = '1;
                    after_l_next = 1'b0;
                    phase_next   = ecbd_pkg::PH_HEADER;
                end
            end
            ecbd_pkg::PH_HEADER: begin
                cnt_next  = cnt_inc;
                cand_next = cand_upd;
                if (!after_l_reg) begin
                    after_l_next = (s_byte_in == ecbd_pkg::CHAR_L);
                end else begin
                    after_l_next = 1'b0;
                    if (s_byte_in == ecbd_pkg::CHAR_F) begin
                        // end mark found; one extra slot for the terminator
                        if ((cnt_inc == CNT_W'(ecbd_pkg::HDR_LEN)) && (cand_upd != '0)) begin
                            cnt_next   = cnt_inc + CNT_W'(1);
                            sel_next   = first_cand;
                            matched    = 1'b1;
                            phase_next = ecbd_pkg::PH_PAYLOAD;
                        end else begin
                            ovf        = ((cnt_inc + CNT_W'(1)) == CNT_W'(MAX_LEN));
                            cnt_next   = '0;
                            cand_next  = '0;
                            phase_next = ecbd_pkg::PH_IDLE;
                        end
                    end
                end
            end
            ecbd_pkg::PH_PAYLOAD: begin
                cnt_next = cnt_inc;
                if (ecbd_pkg::FIRE_W'(cnt_inc) == fire_at) begin
                    phase_next = ecbd_pkg::PH_FIRE;
                end
            end
            ecbd_pkg::PH_FIRE: begin
                // this byte is consumed without inspection
                fire         = 1'b1;
                code         = sel_reg;
                cnt_next     = '0;
                cand_next    = '0;
                after_l_next = 1'b0;
                phase_next   = ecbd_pkg::PH_IDLE;
            end
            default: begin
                cnt_next     = '0;
                cand_next    = '0;
                after_l_next = 1'b0;
                phase_next   = ecbd_pkg::PH_IDLE;
            end
        endcase

        // buffer full: overflow takes priority over a payload end
        if ((phase_next != ecbd_pkg::PH_IDLE) && (cnt_next == CNT_W'(MAX_LEN))) begin
            ovf          = 1'b1;
            cnt_next     = '0;
            cand_next    = '0;
            after_l_next = 1'b0;
            phase_next   = ecbd_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_len_reg <= ecbd_pkg::PAYLOAD_LEN_RESET;
        end else if (cfg_we) begin
            payload_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= ecbd_pkg::PH_IDLE;
            cnt_reg     <= '0;
            cand_reg    <= '0;
            sel_reg     <= '0;
            after_l_reg <= 1'b0;
        end else if (s_accept) begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            cand_reg    <= cand_next;
            sel_reg     <= sel_next;
            after_l_reg <= after_l_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fire_reg    <= fire;
            code_reg    <= code;
            matched_reg <= matched;
            ovf_reg     <= ovf;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_rate_change     = fire_reg;
    assign m_rate_code       = code_reg;
    assign m_header_matched  = matched_reg;
    assign m_length_overflow = ovf_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_cnt_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != ecbd_pkg::PH_IDLE) |-> (cnt_reg < CNT_W'(MAX_LEN)))
        else $error("byte count reached MAX_LEN outside idle");

    a_fire_from_fire_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (phase_reg == ecbd_pkg::PH_FIRE)) |=> (m_valid && m_rate_change))
        else $error("fire byte did not produce rate_change");

    a_code_only_with_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_rate_change) |-> (m_rate_code == '0))
        else $error("rate_code nonzero without rate_change");

    a_state_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(phase_reg) && $stable(cnt_reg)))
        else $error("parser state moved while result stalled");

endmodule
